// ===== sv/huffman_bit_serial_decoder_macros.svh =====
// Assertion helpers for the Huffman tree-walk decoder.
`ifndef HUFFMAN_BIT_SERIAL_DECODER_MACROS_SVH
`define HUFFMAN_BIT_SERIAL_DECODER_MACROS_SVH

// Same-cycle implication, silent during reset
`define HBSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, silent during reset
`define HBSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/hbsd_pkg.sv =====
`timescale 1ns / 1ps

package hbsd_pkg;

	// Node table size and address widths
	localparam int NODE_COUNT = 512;
	localparam int ADDR_W     = 9;
	localparam int TBL_AW     = $clog2(NODE_COUNT);
	localparam int SYM_W      = 8;

	// One tree node as stored in the table
	typedef struct packed {
		logic [ADDR_W-1:0] left_addr;
		logic [ADDR_W-1:0] right_addr;
		logic              leaf;
		logic [SYM_W-1:0]  sym;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	// Input word, lowest field in the lowest bits, padded to 40 bits
	typedef struct packed {
		logic [2:0]        pad;
		logic              code_bit;
		logic [SYM_W-1:0]  leaf_symbol;
		logic              leaf_flag;
		logic [ADDR_W-1:0] right_addr;
		logic [ADDR_W-1:0] left_addr;
		logic [ADDR_W-1:0] node_addr;
	} in_word_t;

	localparam int IN_W = $bits(in_word_t);

	// Item kinds carried in tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic ready;          // input side may take a word
		logic wr_node;        // write the incoming node
		logic rd_cur;         // read the current node
		logic rd_next_cache;  // read child picked from cached node and incoming bit
		logic rd_next_rdata;  // read child picked from read data and held bit
		logic step_rdata;     // move to the node just read
		logic emit_cache;     // emit symbol of cached node
		logic emit_rdata;     // emit symbol of node just read
		logic go_root;        // return to the root
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_decode;
		logic cache_valid;
		logic cache_leaf;
		logic rd_leaf;
		logic out_free;
	} stat_t;

	// True when an address lies outside the table
	function automatic logic addr_oor(input logic [ADDR_W-1:0] a);
		return 32'(a) >= NODE_COUNT;
	endfunction

endpackage

// ===== sv/huffman_bit_serial_decoder.sv =====
`timescale 1ns / 1ps
// Huffman tree-walk decoder.
// Slave channel: s_tuser selects the kind (0 loads a tree node, 1 decodes one
// bit); s_tdata carries the node fields and the code bit. Master channel:
// m_tdata is the decoded byte, produced only when a leaf is reached.
// cfg_we/cfg_wdata set the root address and restart the walk at the root.
// A load word is written into the node table. A decode word reads the child
// of the cached current node (a registered table read), then steps into it,
// or emits its symbol if it is a leaf; a cached node rewritten as a leaf
// emits with no read. The first bit after reset, a root write or an emitted
// symbol fetches the current node first, and emits its symbol if that node
// is a leaf. An emitted symbol appears on m_tvalid the cycle after the leaf is seen.
// The result sits in an output register; the next word is accepted while it
// waits. A walk that reaches a leaf while that register is still full holds
// there until the receiver takes the old symbol.
// Reset clears the root and current node to address 0 and empties the output
// register; the node table itself holds nothing until loaded.

`include "huffman_bit_serial_decoder_macros.svh"

module huffman_bit_serial_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// node_addr[8:0], left_addr[17:9], right_addr[26:18], leaf_flag[27],
	// leaf_symbol[35:28], code_bit[36], zero[39:37]
	input  logic [hbsd_pkg::IN_W-1:0]   s_tdata,
	// op[0]
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// symbol[7:0]
	output logic [hbsd_pkg::SYM_W-1:0]  m_tdata,
	input  logic                        cfg_we,
	input  logic [hbsd_pkg::ADDR_W-1:0] cfg_wdata
);

	hbsd_pkg::cmd_t  cmd;
	hbsd_pkg::stat_t stat;

	hbsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	hbsd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	assign s_tready = cmd.ready;

	// symbols only go to a free output register
	`HBSD_ASSERT_NOW(a_emit_free, cmd.emit_cache || cmd.emit_rdata, stat.out_free, "emit into full output register")
	// node writes only on an accepted load word
	`HBSD_ASSERT_NOW(a_wr_accept, cmd.wr_node, s_tvalid && s_tready && !s_tuser, "node write without load word")
	// at most one table read issued per cycle
	`HBSD_ASSERT_NOW(a_one_read, 1'b1, $onehot0({cmd.rd_cur, cmd.rd_next_cache, cmd.rd_next_rdata}), "several table reads at once")
	// a step into a non-leaf leaves the block ready for the next word
	`HBSD_ASSERT_NEXT(a_step_idle, cmd.step_rdata, s_tready && stat.cache_valid, "no return to idle after step")

endmodule

// ===== sv/hbsd_ram.sv =====
`timescale 1ns / 1ps

module hbsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; rdata holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/hbsd_ctrl.sv =====
`timescale 1ns / 1ps

module hbsd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  hbsd_pkg::stat_t stat,
	output hbsd_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_HERE  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (s_tvalid) begin
					if (!stat.in_decode) begin
						cmd.wr_node = 1'b1;
					end else if (!stat.cache_valid) begin
						cmd.rd_cur = 1'b1;
						state_d    = ST_HERE;
					end else if (stat.cache_leaf) begin
						if (stat.out_free) begin
							cmd.emit_cache = 1'b1;
							cmd.go_root    = 1'b1;
						end else begin
							state_d = ST_EMIT;
						end
					end else begin
						cmd.rd_next_cache = 1'b1;
						state_d           = ST_FETCH;
					end
				end
			end
			ST_HERE: begin
				// current node fetched after reset, a root write or an emitted symbol
				if (stat.rd_leaf) begin
					if (stat.out_free) begin
						cmd.emit_rdata = 1'b1;
						cmd.go_root    = 1'b1;
						state_d        = ST_IDLE;
					end
				end else begin
					cmd.rd_next_rdata = 1'b1;
					state_d           = ST_FETCH;
				end
			end
			ST_FETCH: begin
				// child fetched
				if (stat.rd_leaf) begin
					if (stat.out_free) begin
						cmd.emit_rdata = 1'b1;
						cmd.go_root    = 1'b1;
						state_d        = ST_IDLE;
					end
				end else begin
					cmd.step_rdata = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_EMIT: begin
				// cached leaf waits for the output register
				if (stat.out_free) begin
					cmd.emit_cache = 1'b1;
					cmd.go_root    = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/hbsd_datapath.sv =====
`timescale 1ns / 1ps

module hbsd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hbsd_pkg::IN_W-1:0]     s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [hbsd_pkg::SYM_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [hbsd_pkg::ADDR_W-1:0]   cfg_wdata,
	input  hbsd_pkg::cmd_t                cmd,
	output hbsd_pkg::stat_t               stat
);

	hbsd_pkg::in_word_t                in_w;
	hbsd_pkg::node_t                   wr_node_w;
	hbsd_pkg::node_t                   rd_node;
	hbsd_pkg::node_t                   sel_node;
	logic [hbsd_pkg::NODE_W-1:0]       ram_rdata;
	logic [hbsd_pkg::ADDR_W-1:0]       next_addr;
	logic [hbsd_pkg::ADDR_W-1:0]       rd_addr_d;
	logic                              sel_bit;
	logic                              ram_we;
	logic                              ram_re;

	logic [hbsd_pkg::ADDR_W-1:0]       root_q;
	logic [hbsd_pkg::ADDR_W-1:0]       current_q;
	logic [hbsd_pkg::ADDR_W-1:0]       rd_addr_q;
	logic                              rd_oor_q;
	logic                              bit_q;
	hbsd_pkg::node_t                   cache_q;
	logic                              cache_valid_q;
	logic                              out_valid_q;
	logic [hbsd_pkg::SYM_W-1:0]        out_sym_q;

	assign in_w = hbsd_pkg::in_word_t'(s_tdata);

	assign wr_node_w.left_addr  = in_w.left_addr;
	assign wr_node_w.right_addr = in_w.right_addr;
	assign wr_node_w.leaf       = in_w.leaf_flag;
	assign wr_node_w.sym        = in_w.leaf_symbol;

	// out-of-range reads come back as an empty node
	assign rd_node = rd_oor_q ? '0 : hbsd_pkg::node_t'(ram_rdata);

	// child selection, from the cache in idle or from read data afterwards
	assign sel_node  = cmd.rd_next_cache ? cache_q : rd_node;
	assign sel_bit   = cmd.rd_next_cache ? in_w.code_bit : bit_q;
	assign next_addr = sel_bit ? sel_node.right_addr : sel_node.left_addr;
	assign rd_addr_d = cmd.rd_cur ? current_q : next_addr;

	assign ram_we = cmd.wr_node && !hbsd_pkg::addr_oor(in_w.node_addr);
	assign ram_re = cmd.rd_cur || cmd.rd_next_cache || cmd.rd_next_rdata;

	hbsd_ram #(
		.WIDTH (hbsd_pkg::NODE_W),
		.DEPTH (hbsd_pkg::NODE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (hbsd_pkg::TBL_AW'(in_w.node_addr)),
		.wdata (wr_node_w),
		.re    (ram_re),
		.raddr (hbsd_pkg::TBL_AW'(rd_addr_d)),
		.rdata (ram_rdata)
	);

	// read bookkeeping
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_addr_q <= rd_addr_d;
			rd_oor_q  <= hbsd_pkg::addr_oor(rd_addr_d);
		end
		if (cmd.rd_cur) begin
			bit_q <= in_w.code_bit;
		end
	end

	// cached copy of the current node, kept in step with node writes
	always_ff @(posedge clk) begin
		if (cmd.step_rdata) begin
			cache_q <= rd_node;
		end else if (ram_we && cache_valid_q && in_w.node_addr == current_q) begin
			cache_q <= wr_node_w;
		end
	end

	// root, current node and cache validity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q        <= '0;
			current_q     <= '0;
			cache_valid_q <= 1'b0;
		end else if (cfg_we) begin
			root_q        <= cfg_wdata;
			current_q     <= cfg_wdata;
			cache_valid_q <= 1'b0;
		end else if (cmd.go_root) begin
			current_q     <= root_q;
			cache_valid_q <= 1'b0;
		end else if (cmd.step_rdata) begin
			current_q     <= rd_addr_q;
			cache_valid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cache || cmd.emit_rdata) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cache) begin
			out_sym_q <= cache_q.sym;
		end else if (cmd.emit_rdata) begin
			out_sym_q <= rd_node.sym;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;

	assign stat.in_decode   = (s_tuser == hbsd_pkg::OP_DECODE);
	assign stat.cache_valid = cache_valid_q;
	assign stat.cache_leaf  = cache_q.leaf;
	assign stat.rd_leaf     = rd_node.leaf;
	assign stat.out_free    = !out_valid_q || m_tready;

endmodule
